[sv/aded_pkg.sv]
// shared types, constants and the arctangent step table for the aim direction block
// no dependencies
package aded_pkg;

  localparam int COORD_WIDTH_DEF  = 32;
  localparam int CORDIC_STEPS_DEF = 28;
  localparam int ROT_W            = 26;
  localparam int NORM_W           = 30;
  localparam int NORM_POS         = 29;
  localparam int SQ_STEPS         = 31;
  localparam int SQ_W             = 62;
  localparam int CX_W             = 34;
  localparam int Z_W              = 32;
  localparam int YAW_W            = 31;
  localparam int PITCH_W          = 30;
  localparam int ROLL_W           = 32;
  localparam int ROLL_SH_W        = 36;
  localparam int PROD_W           = 64;
  localparam int DEG_SPLIT        = 18;
  localparam int DEG_PART_W       = 18;

  localparam logic signed [Z_W-1:0] HALF_PI_Q28 = 32'sd421657428;
  localparam logic signed [Z_W-1:0] PI_Q28      = 32'sd843314857;
  localparam logic signed [ROLL_SH_W-1:0] TWO_PI_Q28 = 36'sd1686629713;
  localparam logic signed [DEG_PART_W-1:0] DEG_HI = 18'sd73204;
  localparam logic signed [DEG_PART_W-1:0] DEG_LO = 18'sd108693;

  typedef struct packed {
    logic                     valid;
    logic                     coincide;
    logic signed [NORM_W:0]   dx;
    logic signed [NORM_W:0]   dy;
    logic signed [NORM_W:0]   dz;
    logic signed [ROLL_W-1:0] roll;
  } sq_side_t;

  typedef struct packed {
    logic [SQ_W-1:0] rem;
    logic [SQ_W-1:0] res;
    sq_side_t        side;
  } sq_t;

  typedef struct packed {
    logic signed [CX_W-1:0] x;
    logic signed [CX_W-1:0] y;
    logic signed [Z_W-1:0]  z;
  } rot_t;

  typedef struct packed {
    logic                     valid;
    logic                     coincide;
    logic                     yaw_zero;
    logic                     pitch_vert;
    logic                     dy_neg;
    logic signed [ROLL_W-1:0] roll;
  } cr_side_t;

  function automatic logic signed [Z_W-1:0] atan_q28(input int i);
    logic signed [Z_W-1:0] a;
    begin
      a = '0;
      case (i)
        0: a = 32'sd210828714;
        1: a = 32'sd124459457;
        2: a = 32'sd65760959;
        3: a = 32'sd33381290;
        4: a = 32'sd16755422;
        5: a = 32'sd8385879;
        6: a = 32'sd4193963;
        7: a = 32'sd2097109;
        8: a = 32'sd1048571;
        9: a = 32'sd524287;
        default: a = (i <= 28) ? (Z_W'(1) << (28 - i)) : '0;
      endcase
      return a;
    end
  endfunction

endpackage

[sv/aim_direction_to_euler_angles_top.sv]
// top level: difference, normalization, square root row, two cordic rows, roll scaling
// depends on aded_pkg, aded_sqrt_cell, aded_cordic_cell
//
// channel  dir  data                                                  flags
// in_      in   origin xyz, aim xyz, z_rotation_deg                   -
// out_     out  yaw_angle, pitch_angle, roll_angle                    points_coincide
//
// one request per cycle while the output is not stalled
// the front stages, the 31 square root cells and the cordic cells lie in series
// rst_n clears the valid bits of every stage
// a stalled output freezes the whole row; in_tready follows out_tready
module aim_direction_to_euler_angles_top #(
  parameter int COORD_WIDTH  = aded_pkg::COORD_WIDTH_DEF,
  parameter int CORDIC_STEPS = aded_pkg::CORDIC_STEPS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // origin_x, origin_y, origin_z, aim_x, aim_y, aim_z, z_rotation_deg, zero fill
  input  logic [((6*COORD_WIDTH+aded_pkg::ROT_W+7)/8)*8-1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // yaw_angle, pitch_angle, roll_angle, zero fill
  output logic [95:0] out_tdata,
  // points_coincide
  output logic out_tuser
);
  import aded_pkg::*;

  localparam int CW    = COORD_WIDTH;
  localparam int DW    = CW + 1;
  localparam int POS_W = $clog2(DW);

  logic en;

  logic                       v0_r;
  logic signed [DW-1:0]       d0_r [3];
  logic signed [ROT_W-1:0]    rot0_r;

  logic                       v1_r;
  logic [DW-1:0]              mag1_r [3];
  logic                       neg1_r [3];
  logic [DW-1:0]              max1_r;
  logic signed [ROT_W+DEG_PART_W-1:0] phi1_r, plo1_r;

  logic                       v2_r;
  logic [DW-1:0]              mag2_r [3];
  logic                       neg2_r [3];
  logic                       zero2_r;
  logic [POS_W-1:0]           pos2_r;
  logic [POS_W-1:0]           pos_nxt;
  logic signed [ROLL_W-1:0]   roll2_r;
  logic signed [PROD_W-1:0]   prod;
  logic signed [ROLL_SH_W-1:0] roll_sh;
  logic signed [ROLL_W-1:0]   roll_nxt;

  logic [NORM_W-1:0]          nmag [3];
  sq_side_t                   s3_r, s4_r;
  logic [NORM_W-1:0]          mx3_r, mz3_r;
  logic [2*NORM_W-1:0]        sqx4_r, sqz4_r;

  sq_t                        sq [SQ_STEPS+1];

  rot_t                       yaw_c [CORDIC_STEPS+1];
  rot_t                       pit_c [CORDIC_STEPS+1];
  cr_side_t                   cs_r  [CORDIC_STEPS+1];
  rot_t                       yaw_nxt, pit_nxt;
  cr_side_t                   cs_nxt;
  logic [SQ_STEPS-1:0]        r_root;

  logic                       out_tvalid_r, out_tuser_r;
  logic [95:0]                out_tdata_r;
  logic signed [Z_W-1:0]      yaw_o, pit_o;
  logic signed [ROLL_W-1:0]   roll_o;

  assign en        = !out_tvalid_r || out_tready;
  assign in_tready = en;

  // stage 0: differences
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_tvalid;
      for (int k = 0; k < 3; k++) begin
        d0_r[k] <= $signed({in_tdata[(k+4)*CW-1], in_tdata[(k+3)*CW +: CW]})
                 - $signed({in_tdata[(k+1)*CW-1], in_tdata[k*CW +: CW]});
      end
      rot0_r <= $signed(in_tdata[6*CW +: ROT_W]);
    end
  end

  // stage 1: magnitudes, maximum, roll partial products
  always_ff @(posedge clk) begin
    logic [DW-1:0] m [3];
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      for (int k = 0; k < 3; k++) begin
        m[k] = d0_r[k][DW-1] ? DW'(-d0_r[k]) : DW'(d0_r[k]);
      end
      v1_r <= v0_r;
      for (int k = 0; k < 3; k++) begin
        mag1_r[k] <= m[k];
        neg1_r[k] <= d0_r[k][DW-1];
      end
      max1_r <= (m[0] > m[1]) ? ((m[0] > m[2]) ? m[0] : m[2])
                              : ((m[1] > m[2]) ? m[1] : m[2]);
      phi1_r <= (ROT_W+DEG_PART_W)'(rot0_r) * (ROT_W+DEG_PART_W)'(DEG_HI);
      plo1_r <= (ROT_W+DEG_PART_W)'(rot0_r) * (ROT_W+DEG_PART_W)'(DEG_LO);
    end
  end

  // stage 2: leading one position, roll rounding and clamping
  always_comb begin
    pos_nxt = '0;
    for (int b = 0; b < DW; b++) begin
      if (max1_r[b]) pos_nxt = POS_W'(b);
    end
    prod    = (PROD_W'(phi1_r) <<< DEG_SPLIT) + PROD_W'(plo1_r) + (PROD_W'(1) <<< 27);
    roll_sh = ROLL_SH_W'(prod >>> 28);
    if (roll_sh > TWO_PI_Q28) roll_nxt = ROLL_W'(TWO_PI_Q28);
    else if (roll_sh < -TWO_PI_Q28) roll_nxt = ROLL_W'(-TWO_PI_Q28);
    else roll_nxt = ROLL_W'(roll_sh);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r    <= v1_r;
      mag2_r  <= mag1_r;
      neg2_r  <= neg1_r;
      zero2_r <= (max1_r == '0);
      pos2_r  <= pos_nxt;
      roll2_r <= roll_nxt;
    end
  end

  // stage 3: block normalization
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (pos2_r >= POS_W'(NORM_POS)) nmag[k] = NORM_W'(mag2_r[k] >> (pos2_r - POS_W'(NORM_POS)));
      else nmag[k] = NORM_W'(mag2_r[k] << (POS_W'(NORM_POS) - pos2_r));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_r.valid <= 1'b0;
    end else if (en) begin
      s3_r.valid    <= v2_r;
      s3_r.coincide <= zero2_r;
      s3_r.dx       <= neg2_r[0] ? -$signed({1'b0, nmag[0]}) : $signed({1'b0, nmag[0]});
      s3_r.dy       <= neg2_r[1] ? -$signed({1'b0, nmag[1]}) : $signed({1'b0, nmag[1]});
      s3_r.dz       <= neg2_r[2] ? -$signed({1'b0, nmag[2]}) : $signed({1'b0, nmag[2]});
      s3_r.roll     <= roll2_r;
      mx3_r         <= nmag[0];
      mz3_r         <= nmag[2];
    end
  end

  // stage 4: squares, stage 5: sum into the root row
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_r.valid       <= 1'b0;
      sq[0].side.valid <= 1'b0;
    end else if (en) begin
      s4_r      <= s3_r;
      sqx4_r    <= mx3_r * mx3_r;
      sqz4_r    <= mz3_r * mz3_r;
      sq[0].rem  <= SQ_W'(sqx4_r) + SQ_W'(sqz4_r);
      sq[0].res  <= '0;
      sq[0].side <= s4_r;
    end
  end

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
    aded_sqrt_cell #(.STEP(k)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .a     (sq[k]),
      .q_r   (sq[k+1])
    );
  end

  // start of both cordic rows, quarter turn for yaw when dz is negative
  always_comb begin
    sq_side_t s;
    s      = sq[SQ_STEPS].side;
    r_root = sq[SQ_STEPS].res[SQ_STEPS-1:0];
    if (s.dz < 0) begin
      if (s.dx >= 0) begin
        yaw_nxt.x = CX_W'(s.dx);
        yaw_nxt.y = -CX_W'(s.dz);
        yaw_nxt.z = HALF_PI_Q28;
      end else begin
        yaw_nxt.x = -CX_W'(s.dx);
        yaw_nxt.y = CX_W'(s.dz);
        yaw_nxt.z = -HALF_PI_Q28;
      end
    end else begin
      yaw_nxt.x = CX_W'(s.dz);
      yaw_nxt.y = CX_W'(s.dx);
      yaw_nxt.z = '0;
    end
    pit_nxt.x         = CX_W'($signed({1'b0, r_root}));
    pit_nxt.y         = CX_W'(s.dy);
    pit_nxt.z         = '0;
    cs_nxt.valid      = s.valid;
    cs_nxt.coincide   = s.coincide;
    cs_nxt.yaw_zero   = (s.dx == '0) && (s.dz == '0);
    cs_nxt.pitch_vert = (r_root == '0);
    cs_nxt.dy_neg     = s.dy[NORM_W];
    cs_nxt.roll       = s.roll;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j <= CORDIC_STEPS; j++) cs_r[j].valid <= 1'b0;
    end else if (en) begin
      yaw_c[0] <= yaw_nxt;
      pit_c[0] <= pit_nxt;
      cs_r[0]  <= cs_nxt;
      for (int j = 0; j < CORDIC_STEPS; j++) cs_r[j+1] <= cs_r[j];
    end
  end

  for (genvar j = 0; j < CORDIC_STEPS; j++) begin : g_cordic
    aded_cordic_cell #(.STEP(j)) u_yaw (
      .clk (clk),
      .en  (en),
      .a   (yaw_c[j]),
      .q_r (yaw_c[j+1])
    );
    aded_cordic_cell #(.STEP(j)) u_pitch (
      .clk (clk),
      .en  (en),
      .a   (pit_c[j]),
      .q_r (pit_c[j+1])
    );
  end

  // final clamps and special directions
  always_comb begin
    cr_side_t c;
    c = cs_r[CORDIC_STEPS];
    if (c.coincide || c.yaw_zero) yaw_o = '0;
    else if (yaw_c[CORDIC_STEPS].z > PI_Q28) yaw_o = PI_Q28;
    else if (yaw_c[CORDIC_STEPS].z < -PI_Q28) yaw_o = -PI_Q28;
    else yaw_o = yaw_c[CORDIC_STEPS].z;
    if (c.coincide) pit_o = '0;
    else if (c.pitch_vert) pit_o = c.dy_neg ? -HALF_PI_Q28 : HALF_PI_Q28;
    else if (pit_c[CORDIC_STEPS].z > HALF_PI_Q28) pit_o = HALF_PI_Q28;
    else if (pit_c[CORDIC_STEPS].z < -HALF_PI_Q28) pit_o = -HALF_PI_Q28;
    else pit_o = pit_c[CORDIC_STEPS].z;
    roll_o = c.coincide ? '0 : c.roll;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (en) begin
      out_tvalid_r <= cs_r[CORDIC_STEPS].valid;
      out_tdata_r  <= {3'b000, roll_o, pit_o[PITCH_W-1:0], yaw_o[YAW_W-1:0]};
      out_tuser_r  <= cs_r[CORDIC_STEPS].coincide;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

`ifndef SYNTHESIS
  a_ready_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("input ready does not follow output stall");
  a_coincide_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata == '0))
    else $error("coinciding points with nonzero angles");
  a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[60:31]) <= $signed(30'sd421657428) &&
                    $signed(out_tdata[60:31]) >= -$signed(30'sd421657428)))
    else $error("pitch out of range");
  a_yaw_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[30:0]) <= $signed(31'sd843314857) &&
                    $signed(out_tdata[30:0]) >= -$signed(31'sd843314857)))
    else $error("yaw out of range");
`endif

endmodule

[sv/aded_sqrt_cell.sv]
// one digit step of the integer square root row
// depends on aded_pkg
module aded_sqrt_cell #(
  parameter int STEP = 0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  aded_pkg::sq_t a,
  output aded_pkg::sq_t q_r
);
  import aded_pkg::*;

  localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (SQ_STEPS - 1 - STEP));

  logic [SQ_W-1:0] trial;
  sq_t             q_nxt;

  always_comb begin
    trial = a.res + BIT;
    q_nxt = a;
    if (a.rem >= trial) begin
      q_nxt.rem = a.rem - trial;
      q_nxt.res = (a.res >> 1) + BIT;
    end else begin
      q_nxt.res = a.res >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.side.valid <= 1'b0;
    end else if (en) begin
      q_r <= q_nxt;
    end
  end

endmodule

[sv/aded_cordic_cell.sv]
// one micro-rotation of a vectoring cordic row
// depends on aded_pkg
module aded_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic           clk,
  input  logic           en,
  input  aded_pkg::rot_t a,
  output aded_pkg::rot_t q_r
);
  import aded_pkg::*;

  localparam logic signed [Z_W-1:0] ANGLE = atan_q28(STEP);

  rot_t q_nxt;

  always_comb begin
    if (!a.y[CX_W-1]) begin
      q_nxt.x = a.x + (a.y >>> STEP);
      q_nxt.y = a.y - (a.x >>> STEP);
      q_nxt.z = a.z + ANGLE;
    end else begin
      q_nxt.x = a.x - (a.y >>> STEP);
      q_nxt.y = a.y + (a.x >>> STEP);
      q_nxt.z = a.z - ANGLE;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= q_nxt;
    end
  end

endmodule
